### hw/rtl/adu_pkg.sv
// Shared types, constants and operation codes for the Adam update block.
// Used by adu_alu, adu_mem and adam_update; depends on nothing else.
package adu_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int MAX_ELEMENTS = 4096;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 24;
    localparam int ALU_W        = 64;
    localparam int POW_W        = FRAC_BITS + 1;
    localparam int MHAT_W       = 39;
    localparam int VHAT_W       = 64 - FRAC_BITS;
    localparam int CNT_W        = 7;
    localparam int MUL_STEPS    = 32;
    localparam int DIV_STEPS    = 64;
    localparam int SQRT_STEPS   = 32;

    localparam logic [POW_W-1:0] ONE_FIX    = POW_W'(1) << FRAC_BITS;
    localparam logic [ALU_W-1:0] MHAT_LIMIT = (ALU_W'(1) << MHAT_W) - ALU_W'(1);
    localparam logic [ALU_W-1:0] VHAT_LIMIT = (ALU_W'(1) << VHAT_W) - ALU_W'(1);

    // Shared unit operations.
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LR = 2'd0;
    localparam logic [1:0] REG_B1 = 2'd1;
    localparam logic [1:0] REG_B2 = 2'd2;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] result;
    } t_alu_rsp;

endpackage

### hw/rtl/adu_alu.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-recurrence square root on one 66-bit adder. Depends on adu_pkg.
module adu_alu import adu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_op;
    logic [ALU_W:0]   r_acc;
    logic [ALU_W-1:0] r_a;
    logic [ALU_W-1:0] r_b;
    logic [ALU_W-1:0] r_q;

    logic [ALU_W+1:0] w_p;
    logic [ALU_W+1:0] w_q;
    logic [ALU_W+1:0] w_sum;
    logic [ALU_W:0]   w_shift;
    logic             w_sub;
    logic             w_ok;

    // One adder serves every operation; divide and root bring in new
    // dividend or radicand bits from the top of r_a each step.
    always_comb begin
        w_p     = '0;
        w_q     = '0;
        w_sub   = 1'b0;
        w_shift = '0;
        unique case (r_op)
            OP_MUL: begin
                w_p = {1'b0, r_acc};
                w_q = {2'b00, r_a};
            end
            OP_DIV: begin
                w_shift = {r_acc[ALU_W-1:0], r_a[ALU_W-1]};
                w_p     = {1'b0, w_shift};
                w_q     = {2'b00, r_b};
                w_sub   = 1'b1;
            end
            OP_SQRT: begin
                w_shift = {r_acc[ALU_W-2:0], r_a[ALU_W-1:ALU_W-2]};
                w_p     = {1'b0, w_shift};
                w_q     = {r_q, 2'b01};
                w_sub   = 1'b1;
            end
            default: begin
                w_p = '0;
            end
        endcase
        w_sum = w_p + (w_sub ? ~w_q : w_q) + (ALU_W+2)'(w_sub);
        w_ok  = ~w_sum[ALU_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= (i_req.op == OP_DIV) ? CNT_W'(DIV_STEPS) :
                         (i_req.op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(MUL_STEPS);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_q   <= '0;
        end else if (r_run) begin
            unique case (r_op)
                OP_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= w_sum[ALU_W:0];
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
                OP_DIV: begin
                    r_acc <= w_ok ? w_sum[ALU_W:0] : w_shift;
                    r_q   <= {r_q[ALU_W-2:0], w_ok};
                    r_a   <= r_a << 1;
                end
                OP_SQRT: begin
                    r_acc <= w_ok ? w_sum[ALU_W:0] : w_shift;
                    r_q   <= {r_q[ALU_W-2:0], w_ok};
                    r_a   <= r_a << 2;
                end
                default: begin
                    r_a <= r_a;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == OP_MUL) ? r_acc[ALU_W-1:0] : r_q;

endmodule

### hw/rtl/adu_mem.sv
// Moment store: one word per element holding the first and second moment.
// One write port and one registered read port. Depends on adu_pkg.
module adu_mem import adu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [2*DATA_W-1:0]   i_wdata,
    input  logic                  i_re,
    input  logic [IDX_W-1:0]      i_raddr,
    output logic [2*DATA_W-1:0]   o_rdata
);

    logic [2*DATA_W-1:0] r_mem [MAX_ELEMENTS];
    logic [2*DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/adam_update.sv
// Adam update top level: sequencer, configuration registers and output word.
// Setting new_pass runs the bias-power steps POW1 and POW2 first; the
// next word is taken once the previous result has moved to the output register.
// Reset clears the control state and then sweeps the 4096-entry moment store
// to zero, during which no input word is taken.
// Depends on adu_pkg, adu_alu and adu_mem.
module adam_update import adu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [DATA_W-1:0] i_param_value,
    input  logic signed [DATA_W-1:0] i_gradient,
    input  logic                     i_new_pass,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_out_index,
    output logic signed [DATA_W-1:0] o_new_param_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Sequencer states. Each shared-unit state issues one operation to the
    // shared unit, waits for it to finish and captures the result.
    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_POW1    = 5'd2;
    localparam logic [4:0] S_POW2    = 5'd3;
    localparam logic [4:0] S_MUL_M   = 5'd4;
    localparam logic [4:0] S_MUL_G   = 5'd5;
    localparam logic [4:0] S_MSUM    = 5'd6;
    localparam logic [4:0] S_MMAG    = 5'd7;
    localparam logic [4:0] S_MUL_SQ  = 5'd8;
    localparam logic [4:0] S_MUL_V   = 5'd9;
    localparam logic [4:0] S_MUL_GV  = 5'd10;
    localparam logic [4:0] S_VSUM    = 5'd11;
    localparam logic [4:0] S_DIV_M   = 5'd12;
    localparam logic [4:0] S_DIV_V   = 5'd13;
    localparam logic [4:0] S_SQRT    = 5'd14;
    localparam logic [4:0] S_MUL_LR  = 5'd15;
    localparam logic [4:0] S_DIV_U   = 5'd16;
    localparam logic [4:0] S_OUT     = 5'd17;

    // Configuration registers.
    logic [CFG_W-1:0] r_lr;
    logic [CFG_W-1:0] r_b1;
    logic [CFG_W-1:0] r_b2;

    // Control state.
    logic [4:0]       r_state;
    logic             r_wait;
    logic [IDX_W-1:0] r_clr;
    logic             r_out_valid;

    // Per-word working registers.
    logic [IDX_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_param;
    logic [DATA_W-1:0]        r_gmag;
    logic                     r_gneg;
    logic [POW_W-1:0]         r_p1;
    logic [POW_W-1:0]         r_p2;
    logic signed [ALU_W-1:0]  r_t1;
    logic signed [ALU_W-1:0]  r_t2;
    logic signed [DATA_W-1:0] r_m;
    logic [DATA_W-1:0]        r_mmag;
    logic [VHAT_W-1:0]        r_gsq;
    logic [DATA_W-1:0]        r_v;
    logic [MHAT_W-1:0]        r_mhat;
    logic [VHAT_W-1:0]        r_vhat;
    logic [DATA_W-1:0]        r_den;
    logic [ALU_W-1:0]         r_prod;
    logic [ALU_W-1:0]         r_upd;
    logic [IDX_W-1:0]         r_out_idx;
    logic signed [DATA_W-1:0] r_out_val;

    t_alu_req w_req;
    t_alu_rsp w_rsp;
    logic     w_alu_state;
    logic     w_in_acc;
    logic     w_cfg_wr;
    logic     w_out_take;

    logic                     w_mem_we;
    logic [IDX_W-1:0]         w_mem_waddr;
    logic [2*DATA_W-1:0]      w_mem_wdata;
    logic [2*DATA_W-1:0]      w_mem_rdata;
    logic signed [DATA_W-1:0] w_mold;
    logic [DATA_W-1:0]        w_mold_mag;
    logic [DATA_W-1:0]        w_vold;

    logic [POW_W-1:0]        w_c1;
    logic [POW_W-1:0]        w_c2;
    logic [ALU_W-1:0]        w_vsum;
    logic [VHAT_W-1:0]       w_vnew;
    logic signed [DATA_W:0]  w_pext;
    logic signed [ALU_W:0]   w_res;
    logic signed [DATA_W-1:0] w_res_sat;

    // ------------------------------------------------------------------
    // Configuration port. Writes land at psel && penable && pwrite; the
    // registers keep the low 24 bits of the written word.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= CFG_W'(16777);
            r_b1 <= CFG_W'(15099494);
            r_b2 <= CFG_W'(16760439);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_LR:  r_lr <= pwdata[CFG_W-1:0];
                REG_B1:  r_b1 <= pwdata[CFG_W-1:0];
                REG_B2:  r_b2 <= pwdata[CFG_W-1:0];
                default: r_lr <= r_lr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LR:  prdata = 32'(r_lr);
            REG_B1:  prdata = 32'(r_b1);
            REG_B2:  prdata = 32'(r_b2);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. A word is taken only in the idle state; the output
    // register lets the next word start while a result still waits.
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // ------------------------------------------------------------------
    // Moment store. The upper half of a word is the signed first moment,
    // the lower half the unsigned second moment.
    // ------------------------------------------------------------------
    assign w_mem_we    = (r_state == S_CLEAR) || ((r_state == S_DIV_M) && !r_wait);
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign w_mem_wdata = (r_state == S_CLEAR) ? '0 : {r_m, r_v};

    adu_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_in_acc),
        .i_raddr (i_element_index),
        .o_rdata (w_mem_rdata)
    );

    assign w_mold     = w_mem_rdata[2*DATA_W-1:DATA_W];
    assign w_mold_mag = w_mold[DATA_W-1] ? DATA_W'(-w_mold) : DATA_W'(w_mold);
    assign w_vold     = w_mem_rdata[DATA_W-1:0];

    // Bias corrections; a zero correction is taken as one LSB.
    assign w_c1 = ((ONE_FIX - r_p1) == '0) ? POW_W'(1) : (ONE_FIX - r_p1);
    assign w_c2 = ((ONE_FIX - r_p2) == '0) ? POW_W'(1) : (ONE_FIX - r_p2);

    // ------------------------------------------------------------------
    // Operand selection for the shared unit.
    // ------------------------------------------------------------------
    always_comb begin
        w_alu_state = 1'b1;
        w_req.op    = OP_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        unique case (r_state)
            S_POW1: begin
                w_req.a = ALU_W'(r_p1);
                w_req.b = ALU_W'(r_b1);
            end
            S_POW2: begin
                w_req.a = ALU_W'(r_p2);
                w_req.b = ALU_W'(r_b2);
            end
            S_MUL_M: begin
                w_req.a = ALU_W'(w_mold_mag);
                w_req.b = ALU_W'(r_b1);
            end
            S_MUL_G: begin
                w_req.a = ALU_W'(r_gmag);
                w_req.b = ALU_W'(ONE_FIX - POW_W'(r_b1));
            end
            S_MUL_SQ: begin
                w_req.a = ALU_W'(r_gmag);
                w_req.b = ALU_W'(r_gmag);
            end
            S_MUL_V: begin
                w_req.a = ALU_W'(w_vold);
                w_req.b = ALU_W'(r_b2);
            end
            S_MUL_GV: begin
                w_req.a = ALU_W'(r_gsq);
                w_req.b = ALU_W'(ONE_FIX - POW_W'(r_b2));
            end
            S_DIV_M: begin
                w_req.op = OP_DIV;
                w_req.a  = ALU_W'({r_mmag, {FRAC_BITS{1'b0}}});
                w_req.b  = ALU_W'(w_c1);
            end
            S_DIV_V: begin
                w_req.op = OP_DIV;
                w_req.a  = ALU_W'({r_v, {FRAC_BITS{1'b0}}});
                w_req.b  = ALU_W'(w_c2);
            end
            S_SQRT: begin
                w_req.op = OP_SQRT;
                w_req.a  = ALU_W'({r_vhat, {FRAC_BITS{1'b0}}});
            end
            S_MUL_LR: begin
                w_req.a = ALU_W'(r_mhat);
                w_req.b = ALU_W'(r_lr);
            end
            S_DIV_U: begin
                w_req.op = OP_DIV;
                w_req.a  = r_prod;
                w_req.b  = ALU_W'(r_den);
            end
            default: begin
                w_alu_state = 1'b0;
            end
        endcase
        w_req.start = w_alu_state && !r_wait;
    end

    adu_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // New second moment; it is saturated to 32 bits when stored in r_v.
    assign w_vsum = ALU_W'(r_t1) + ALU_W'(r_t2);
    assign w_vnew = VHAT_W'(w_vsum >> FRAC_BITS);

    // Final result: param minus the signed update, saturated to Q8.24.
    assign w_pext = (DATA_W+1)'(r_param);
    assign w_res  = r_m[DATA_W-1] ? ((ALU_W+1)'(w_pext) + $signed({1'b0, r_upd}))
                                  : ((ALU_W+1)'(w_pext) - $signed({1'b0, r_upd}));
    always_comb begin
        if (w_res > (ALU_W+1)'(signed'(33'sh0_7FFF_FFFF))) begin
            w_res_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_res < (ALU_W+1)'(signed'(33'sh1_8000_0000))) begin
            w_res_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_res_sat = DATA_W'(w_res);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer control.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wait      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_p1        <= ONE_FIX;
            r_p2        <= ONE_FIX;
        end else begin
            // A new result takes precedence over the hand-off of the old one.
            if (w_out_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_alu_state) begin
                if (!r_wait) begin
                    r_wait <= 1'b1;
                end else if (w_rsp.done) begin
                    r_wait <= 1'b0;
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(MAX_ELEMENTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= i_new_pass ? S_POW1 : S_MUL_M;
                    end
                end
                S_POW1: begin
                    if (r_wait && w_rsp.done) begin
                        r_p1    <= w_rsp.result[FRAC_BITS +: POW_W];
                        r_state <= S_POW2;
                    end
                end
                S_POW2: begin
                    if (r_wait && w_rsp.done) begin
                        r_p2    <= w_rsp.result[FRAC_BITS +: POW_W];
                        r_state <= S_MUL_M;
                    end
                end
                S_MSUM:  r_state <= S_MMAG;
                S_MMAG:  r_state <= S_MUL_SQ;
                S_VSUM:  r_state <= S_DIV_M;
                S_OUT: begin
                    if (w_out_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    if (r_wait && w_rsp.done) begin
                        r_state <= r_state + 5'd1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Working registers, loaded as each operation completes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_idx   <= i_element_index;
            r_param <= i_param_value;
            r_gneg  <= i_gradient[DATA_W-1];
            r_gmag  <= i_gradient[DATA_W-1] ? DATA_W'(-i_gradient) : DATA_W'(i_gradient);
        end
        if (r_wait && w_rsp.done) begin
            unique case (r_state)
                S_MUL_M:  r_t1 <= w_mold[DATA_W-1] ? -$signed(w_rsp.result)
                                                   : $signed(w_rsp.result);
                S_MUL_G:  r_t2 <= r_gneg ? -$signed(w_rsp.result) : $signed(w_rsp.result);
                S_MUL_SQ: r_gsq <= VHAT_W'(w_rsp.result >> FRAC_BITS);
                S_MUL_V:  r_t1 <= $signed(w_rsp.result);
                S_MUL_GV: r_t2 <= $signed(w_rsp.result);
                S_DIV_M:  r_mhat <= (w_rsp.result > MHAT_LIMIT) ? MHAT_W'(MHAT_LIMIT)
                                                                : MHAT_W'(w_rsp.result);
                S_DIV_V:  r_vhat <= (w_rsp.result >= VHAT_LIMIT) ? VHAT_W'(VHAT_LIMIT)
                                                     : VHAT_W'(w_rsp.result + ALU_W'(1));
                S_SQRT:   r_den <= (w_rsp.result == '0) ? DATA_W'(1)
                                                        : DATA_W'(w_rsp.result);
                S_MUL_LR: r_prod <= w_rsp.result;
                S_DIV_U:  r_upd <= w_rsp.result;
                default:  r_prod <= r_prod;
            endcase
        end
        // The decayed mean stays within the 32-bit range, so the floor of
        // the shifted sum fits the stored first moment.
        if (r_state == S_MSUM) begin
            r_m <= DATA_W'((r_t1 + r_t2) >>> FRAC_BITS);
        end
        if (r_state == S_MMAG) begin
            r_mmag <= r_m[DATA_W-1] ? DATA_W'(-r_m) : DATA_W'(r_m);
        end
        if (r_state == S_VSUM) begin
            r_v <= (w_vnew[VHAT_W-1:DATA_W] != '0) ? {DATA_W{1'b1}} : DATA_W'(w_vnew);
        end
        if (w_out_take) begin
            r_out_idx <= r_idx;
            r_out_val <= w_res_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_index       = r_out_idx;
    assign o_new_param_value = r_out_val;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken again right after an accept");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_wait && w_alu_state))
        else $error("shared unit finished with no operation pending");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result register overwritten while stalled");

endmodule
